// File: rtl/core/pphm_pkg.sv
// types and constants shared by the perturbation-probe hash map unit
// and its port checker; depends on nothing else
`default_nettype none

package pphm_pkg;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 64;
  localparam int ENTRY_W = 9;
  localparam int COUNT_W = 32;

  // configuration register map (byte offsets)
  localparam logic [1:0] ADDR_SIZE_LOG2 = 2'd0;
  localparam logic [3:0] SIZE_LOG2_RESET = 4'd8;

  // operations
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_SET    = 1'b1;

  // result status codes
  localparam logic [1:0] ST_HIT       = 2'd0;
  localparam logic [1:0] ST_INSERTED  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic                 cmd;
    logic [KEY_W-1:0]     key_id;
    logic [31:0]          key_hash;
    logic [VALUE_W-1:0]   new_value;
  } item_t;

  typedef struct packed {
    logic                 found;
    logic [VALUE_W-1:0]   read_value;
    logic [1:0]           status;
    logic [ENTRY_W-1:0]   entries;
    logic [COUNT_W-1:0]   changes;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/perturb_probe_hash_map_unit.sv
// open-addressing hash map with perturbation probing over one slot memory
// depends on pphm_pkg for the item and result types and the codes
//
//   channel   handshake          payload       notes
//   input     start / busy       item          taken when start && !busy
//   output    done               result        one-cycle strobe, no back-pressure
//   config    apb psel/penable   pwdata[3:0]   size_log2 at byte offset 0
//
// an item is taken in idle and then probes P slots, one registered slot memory
// read for each; P is at most 2^s + 8, s being size_log2 clamped into
// 2..LOG2_SLOTS
// after reset a clearing pass writes every slot invalid, with busy high;
// config writes are taken throughout
// results cannot be stalled; done rises in the cycle after the last probe
`default_nettype none

module perturb_probe_hash_map_unit #(
  parameter int LOG2_SLOTS = 8,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire pphm_pkg::item_t  item,
  output logic                  done,
  output pphm_pkg::result_t     result,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [1:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int SLOTS = 1 << LOG2_SLOTS;
  localparam int KW    = (KEY_BITS < pphm_pkg::KEY_W) ? KEY_BITS : pphm_pkg::KEY_W;
  localparam int MW    = 1 + KW + VALUE_BITS;
  localparam int CW    = LOG2_SLOTS + 1;
  localparam int NW    = CW + 4;
  localparam int EW    = (CW < pphm_pkg::ENTRY_W) ? CW : pphm_pkg::ENTRY_W;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_PROBE = 3'b100
  } state_t;

  state_t                  state, state_next;
  logic [LOG2_SLOTS-1:0]   clr_idx, clr_idx_next;
  logic [LOG2_SLOTS-1:0]   idx, idx_next, idx_step;
  logic [31:0]             perturb, perturb_next;
  logic [NW-1:0]           cnt, cnt_next;
  logic [CW-1:0]           entry_count, entry_count_next;
  logic [31:0]             change_count, change_count_next;
  logic [3:0]              size_log2;
  pphm_pkg::item_t         item_q;
  pphm_pkg::result_t       result_next;
  logic                    done_next;
  logic                    accept;

  // slot memory: {valid, key, value}
  logic [MW-1:0]           slot_mem [SLOTS];
  logic [MW-1:0]           rd_data, wr_data;
  logic [LOG2_SLOTS-1:0]   rd_addr, wr_addr;
  logic                    mem_we;

  // size and limits
  logic [4:0]              size_used;
  logic [CW-1:0]           mask_wide, slots, quarter, thresh;
  logic [LOG2_SLOTS-1:0]   mask;
  logic [NW-1:0]           limit;

  // probe evaluation
  logic                    slot_valid, slot_hit, slot_empty, exhausted, finish;
  logic                    is_set;
  logic [VALUE_BITS-1:0]   new_val;
  logic [VALUE_BITS-1:0]   slot_val;
  logic [pphm_pkg::VALUE_W-1:0] read_ext;
  logic [pphm_pkg::ENTRY_W-1:0] entries_ext;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);
  assign pready = 1'b1;

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2 <= pphm_pkg::SIZE_LOG2_RESET;
    end else if (psel && penable && pwrite && paddr == pphm_pkg::ADDR_SIZE_LOG2) begin
      size_log2 <= pwdata[3:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == pphm_pkg::ADDR_SIZE_LOG2) begin
      prdata[3:0] = size_log2;
    end
  end

  // clamp size into 2..LOG2_SLOTS and derive mask, load threshold, probe limit
  always_comb begin
    size_used = {1'b0, size_log2};
    if (size_used < 5'd2) begin
      size_used = 5'd2;
    end else if (size_used > 5'(LOG2_SLOTS)) begin
      size_used = 5'(LOG2_SLOTS);
    end
    slots     = CW'(1) << size_used;
    mask_wide = slots - CW'(1);
    mask      = mask_wide[LOG2_SLOTS-1:0];
    quarter   = slots >> 2;
    thresh    = quarter + (quarter << 1);
    limit     = NW'(slots) + NW'(8);
  end

  assign idx_step   = ((idx << 2) + idx + perturb[LOG2_SLOTS-1:0] + LOG2_SLOTS'(1)) & mask;
  assign slot_valid = rd_data[MW-1];
  assign slot_val   = rd_data[VALUE_BITS-1:0];
  assign slot_hit   = slot_valid && (rd_data[VALUE_BITS +: KW] == item_q.key_id[KW-1:0]);
  assign slot_empty = !slot_valid;
  assign exhausted  = !slot_hit && !slot_empty && ((cnt + NW'(1)) == limit);
  assign finish     = slot_hit || slot_empty || exhausted;
  assign is_set     = (item_q.cmd == pphm_pkg::CMD_SET);
  assign new_val    = item_q.new_value[VALUE_BITS-1:0];

  always_comb begin
    read_ext = '0;
    read_ext[VALUE_BITS-1:0] = slot_val;
  end

  always_comb begin
    entries_ext = '0;
    entries_ext[EW-1:0] = entry_count_next[EW-1:0];
  end

  always_comb begin
    state_next        = state;
    clr_idx_next      = clr_idx;
    idx_next          = idx;
    perturb_next      = perturb;
    cnt_next          = cnt;
    entry_count_next  = entry_count;
    change_count_next = change_count;
    done_next         = 1'b0;
    result_next       = result;
    mem_we            = 1'b0;
    wr_addr           = idx;
    wr_data           = rd_data;
    rd_addr           = idx_step;

    case (state)
      S_CLEAR: begin
        mem_we       = 1'b1;
        wr_addr      = clr_idx;
        wr_data      = '0;
        clr_idx_next = clr_idx + LOG2_SLOTS'(1);
        if (&clr_idx) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        rd_addr = item.key_hash[LOG2_SLOTS-1:0] & mask;
        if (start) begin
          idx_next     = item.key_hash[LOG2_SLOTS-1:0] & mask;
          perturb_next = item.key_hash;
          cnt_next     = '0;
          state_next   = S_PROBE;
        end
      end
      S_PROBE: begin
        idx_next     = idx_step;
        perturb_next = perturb >> 5;
        cnt_next     = cnt + NW'(1);
        if (finish) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
          result_next.found      = slot_hit;
          result_next.read_value = '0;
          if (!is_set) begin
            if (slot_hit) begin
              result_next.read_value = read_ext;
              result_next.status     = pphm_pkg::ST_HIT;
            end else begin
              result_next.status = pphm_pkg::ST_NOT_FOUND;
            end
          end else if (slot_hit) begin
            mem_we            = 1'b1;
            wr_data           = {1'b1, rd_data[VALUE_BITS +: KW], new_val};
            change_count_next = change_count + 32'd1;
            result_next.status = pphm_pkg::ST_HIT;
          end else if (slot_empty && entry_count < thresh) begin
            mem_we            = 1'b1;
            wr_data           = {1'b1, item_q.key_id[KW-1:0], new_val};
            entry_count_next  = entry_count + CW'(1);
            change_count_next = change_count + 32'd1;
            result_next.status = pphm_pkg::ST_INSERTED;
          end else begin
            result_next.status = pphm_pkg::ST_FULL;
          end
          result_next.entries = entries_ext;
          result_next.changes = change_count_next;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      entry_count  <= '0;
      change_count <= '0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      clr_idx      <= clr_idx_next;
      entry_count  <= entry_count_next;
      change_count <= change_count_next;
      done         <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    perturb <= perturb_next;
    cnt     <= cnt_next;
    result  <= result_next;
    if (accept) begin
      item_q <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[wr_addr] <= wr_data;
    end
    rd_data <= slot_mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: rtl/core/pphm_checker.sv
// port-level checks for the perturbation-probe hash map unit, bound to the top
// depends on pphm_pkg for the result type
`default_nettype none

module pphm_port_checks (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire pphm_pkg::result_t result
);

  // an accepted item moves the unit into its busy probe state
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("unit not busy after taking an item");

  // every item passes through the probe state, so results never come back to back
  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results in consecutive cycles");

  // a result is shown only once the unit is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result while still busy");

  // no result without an item in flight
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !busy |=> !done)
    else $error("result with no item in flight");

  // a result that reports the key as present always carries the hit status
  a_found_status: assert property (@(posedge clk) disable iff (rst)
    (done && result.found) |-> (result.status == pphm_pkg::ST_HIT))
    else $error("found key with a status other than hit");

endmodule

bind perturb_probe_hash_map_unit pphm_port_checks u_pphm_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

// File: tb/pphm_checker.sv
// item and result watcher for the perturbation-probe hash map unit: keeps its own
// copy of the slot store and the size register, predicts each result and compares
// depends on pphm_pkg for the item and result types and the codes
`timescale 1ns / 100ps

module pphm_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  pphm_pkg::item_t   item,
  input  logic              done,
  input  pphm_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                fails,
  output int                pending
);

  localparam int STORE_SLOTS = 256;

  typedef enum int {PROBE_HIT, PROBE_EMPTY, PROBE_EXHAUSTED} probe_outcome_t;

  logic                         map_valid [STORE_SLOTS];
  logic [pphm_pkg::KEY_W-1:0]   map_key   [STORE_SLOTS];
  logic [pphm_pkg::VALUE_W-1:0] map_value [STORE_SLOTS];
  logic [pphm_pkg::ENTRY_W-1:0] entry_cnt;
  logic [pphm_pkg::COUNT_W-1:0] change_cnt;
  logic [3:0]                   size_reg;
  pphm_pkg::result_t            awaited_results [$];
  pphm_pkg::result_t            want;

  // walks the probe chain and applies the item to the local copy of the map
  function automatic pphm_pkg::result_t hash_map_access(pphm_pkg::item_t it);
    int unsigned       used, slots, mask, idx, perturb, n, where;
    probe_outcome_t    outcome;
    pphm_pkg::result_t r;
    used = size_reg;
    if (used < 2) used = 2;
    if (used > 8) used = 8;
    slots = 1 << used;
    mask = slots - 1;
    idx = it.key_hash & mask;
    perturb = it.key_hash;
    outcome = PROBE_EXHAUSTED;
    where = 0;
    // at most slots + 8 visits, the same probe limit as the unit
    for (n = 0; n < slots + 8 && outcome == PROBE_EXHAUSTED; n++) begin
      if (!map_valid[idx]) begin
        outcome = PROBE_EMPTY;
        where = idx;
      end else if (map_key[idx] == it.key_id) begin
        outcome = PROBE_HIT;
        where = idx;
      end else begin
        idx = (idx * 5 + perturb + 1) & mask;
        perturb = perturb >> 5;
      end
    end
    r = '0;
    r.found = (outcome == PROBE_HIT);
    if (it.cmd == pphm_pkg::CMD_LOOKUP) begin
      if (outcome == PROBE_HIT) begin
        r.read_value = map_value[where];
        r.status = pphm_pkg::ST_HIT;
      end else begin
        r.status = pphm_pkg::ST_NOT_FOUND;
      end
    end else if (outcome == PROBE_HIT) begin
      map_value[where] = it.new_value;
      change_cnt++;
      r.status = pphm_pkg::ST_HIT;
    end else if (outcome == PROBE_EMPTY && entry_cnt < slots / 4 * 3) begin
      map_valid[where] = 1'b1;
      map_key[where] = it.key_id;
      map_value[where] = it.new_value;
      entry_cnt++;
      change_cnt++;
      r.status = pphm_pkg::ST_INSERTED;
    end else begin
      r.status = pphm_pkg::ST_FULL;
    end
    r.entries = entry_cnt;
    r.changes = change_cnt;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] expected_val, logic [63:0] seen);
    if (seen !== expected_val) begin
      $error("%s mismatch: expected %0h, got %0h", name, expected_val, seen);
      fails++;
    end
  endtask

  initial begin
    fails = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STORE_SLOTS; i++) map_valid[i] = 1'b0;
      entry_cnt = '0;
      change_cnt = '0;
      size_reg = pphm_pkg::SIZE_LOG2_RESET;
      awaited_results.delete();
    end else begin
      // results first, so an item taken at this edge cannot match them
      if (done) begin
        if (awaited_results.size() == 0) begin
          $error("result with no item outstanding");
          fails++;
        end else begin
          want = awaited_results.pop_front();
          check_field("found", want.found, result.found);
          check_field("read_value", want.read_value, result.read_value);
          check_field("status", want.status, result.status);
          check_field("entries", want.entries, result.entries);
          check_field("changes", want.changes, result.changes);
        end
      end
      if (psel && penable && pwrite && pready && paddr == pphm_pkg::ADDR_SIZE_LOG2)
        size_reg = pwdata[3:0];
      if (start && !busy)
        awaited_results.push_back(hash_map_access(item));
    end
    pending = awaited_results.size();
  end

endmodule

// File: tb/tb_perturb_probe_hash_map_unit.sv
// top of the hash map unit testbench: clock, reset, item and register stimulus
// and the verdict; depends on pphm_pkg, pphm_checker and the unit itself
`timescale 1ns / 100ps

module tb_perturb_probe_hash_map_unit;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  pphm_pkg::item_t   item;
  logic              done;
  pphm_pkg::result_t result;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [1:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                fails;
  int                pending;

  int          idle_pct;
  logic [31:0] pool_key  [$];
  logic [31:0] pool_hash [$];

  perturb_probe_hash_map_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  pphm_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // leaves start high after the item is taken; the next call or a drain decides
  task automatic send(logic c, logic [31:0] k, logic [31:0] h, logic [63:0] v);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    item.cmd <= c;
    item.key_id <= k;
    item.key_hash <= h;
    item.new_value <= v;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
  endtask

  task automatic write_size(logic [3:0] sz);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= pphm_pkg::ADDR_SIZE_LOG2;
    pwdata <= {28'($urandom), sz};
    @(negedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // mostly keys already seen with their own hash, some with a stray hash
  task automatic random_item();
    int          r;
    int          sel;
    logic        c;
    logic [31:0] k;
    logic [31:0] h;
    logic [63:0] v;
    c = ($urandom_range(99) < 55) ? pphm_pkg::CMD_SET : pphm_pkg::CMD_LOOKUP;
    r = $urandom_range(99);
    if (pool_key.size() != 0 && r < 60) begin
      sel = $urandom_range(pool_key.size() - 1);
      k = pool_key[sel];
      h = (r >= 53) ? 32'($urandom) : pool_hash[sel];
    end else begin
      k = $urandom;
      if (k == '0) k = 32'd1;
      h = $urandom;
      // crowd the low hash bits so chains grow long
      if ($urandom_range(1) == 1) h[7:0] = 8'($urandom_range(7));
      if (c == pphm_pkg::CMD_SET && pool_key.size() < 512) begin
        pool_key.push_back(k);
        pool_hash.push_back(h);
      end
    end
    case ($urandom_range(9))
      0: v = '0;
      1: v = '1;
      default: v = {32'($urandom), 32'($urandom)};
    endcase
    send(c, k, h, v);
  endtask

  initial begin
    int phase_size  [11];
    int phase_items [11];
    int sent;
    phase_size  = '{0, 1, 3, 4, 5, 6, 7, 8, 15, 2, 8};
    phase_items = '{40, 20, 60, 80, 100, 120, 180, 250, 100, 60, 90};
    sent = 0;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_pct = 0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // at the reset size: top slot, all-ones key, hash and value
    send(pphm_pkg::CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1);
    send(pphm_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    drain();
    write_size(4'd2);
    // shrunk below an entry: it is no longer reachable but still counts
    send(pphm_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h1234);
    send(pphm_pkg::CMD_SET, 32'h0, 32'h0, '0);
    send(pphm_pkg::CMD_LOOKUP, 32'h0, 32'h0, '1);
    send(pphm_pkg::CMD_SET, 32'h1, 32'h0, 64'h0123_4567_89AB_CDEF);
    // load limit reached: collision chain ends in a free slot, still refused
    send(pphm_pkg::CMD_SET, 32'h2, 32'h0, 64'h77);
    send(pphm_pkg::CMD_SET, 32'h1, 32'h0, '1);
    send(pphm_pkg::CMD_LOOKUP, 32'h1, 32'h0, '0);
    send(pphm_pkg::CMD_LOOKUP, 32'h3, 32'hFFFF_FFFF, '0);
    send(pphm_pkg::CMD_SET, 32'h0, 32'h8000_0000, 64'hAAAA_AAAA_AAAA_AAAA);
    send(pphm_pkg::CMD_LOOKUP, 32'h7, 32'h0000_0001, '0);
    send(pphm_pkg::CMD_LOOKUP, 32'h0, 32'h8000_0000, '0);
    drain();
    write_size(4'd15);
    send(pphm_pkg::CMD_SET, 32'h2, 32'h0000_0002, 64'h5555_5555_5555_5555);
    send(pphm_pkg::CMD_LOOKUP, 32'h2, 32'h0000_0002, '0);
    send(pphm_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);

    for (int p = 0; p < 11; p++) begin
      drain();
      write_size(4'(phase_size[p]));
      for (int i = 0; i < phase_items[p]; i++) begin
        idle_pct = (sent < 367) ? 26 : (sent < 734) ? 85 : 0;
        if ($urandom_range(39) == 0) drain();
        random_item();
        sent++;
      end
    end

    drain();
    repeat (300) @(negedge clk);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/pphm_pkg.sv
rtl/core/perturb_probe_hash_map_unit.sv
rtl/core/pphm_checker.sv
tb/pphm_checker.sv
tb/tb_perturb_probe_hash_map_unit.sv
